// ===== hw/rtl/sojourn_ecn_marking_queue_core_macros.svh =====
// Assertion macros shared by the queue core.
`ifndef SOJOURN_ECN_MARKING_QUEUE_CORE_MACROS_SVH
`define SOJOURN_ECN_MARKING_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

  localparam int QUEUE_DEPTH_DEF = 1024;
  localparam int TIME_W    = 48;
  localparam int BYTES_W   = 16;
  localparam int ECN_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int MAXPKT_W  = 11;
  localparam int MAXBYTE_W = 24;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [MAXPKT_W-1:0]  MAX_PACKETS_RST = MAXPKT_W'(100);
  localparam logic [MAXBYTE_W-1:0] MAX_BYTES_RST   = MAXBYTE_W'(150000);
  localparam logic [TIME_W-1:0]    INSTANT_RST     = TIME_W'(20000);
  localparam logic [TIME_W-1:0]    INTERVAL_RST    = TIME_W'(100000);
  localparam logic [TIME_W-1:0]    TARGET_RST      = TIME_W'(10000);

  // Control law sequencing: square, divide, square root.
  localparam int SQR_STEPS  = TIME_W;
  localparam int DIV_STEPS  = 2 * TIME_W;
  localparam int SQRT_STEPS = TIME_W;
  localparam int STEP_W     = 7;

  localparam logic [ECN_W-1:0] ECN_MARKABLE = 2'd1;
  localparam logic [ECN_W-1:0] ECN_CE       = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED  = 2'd0,
    STAT_DROPPED   = 2'd1,
    STAT_DELIVERED = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_MODE  = 3'd0,
    CFG_MAX_PACKETS = 3'd1,
    CFG_MAX_BYTES   = 3'd2,
    CFG_INSTANT     = 3'd3,
    CFG_INTERVAL    = 3'd4,
    CFG_TARGET      = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ, S_DEQ, S_EVAL, S_SQR, S_DIV, S_SQRT, S_LAW, S_RESP
  } state_t;

  // Saturating 48-bit time sum.
  function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sem_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sem_req_if;
  import sem_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [TIME_W-1:0]   now_time;
  logic [BYTES_W-1:0]  pkt_bytes;
  logic [ECN_W-1:0]    ecn_in;
  modport source(output valid, req_type, now_time, pkt_bytes, ecn_in, input ready);
  modport sink(input valid, req_type, now_time, pkt_bytes, ecn_in, output ready);
endinterface

interface sem_rsp_if;
  import sem_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ECN_W-1:0]    ecn_out;
  logic                ce_marked;
  logic                instant_mark;
  logic                persist_mark;
  logic [TIME_W-1:0]   sojourn_time;
  logic [BYTES_W-1:0]  out_bytes;
  modport source(output valid, status, ecn_out, ce_marked, instant_mark, persist_mark,
                 sojourn_time, out_bytes, input ready);
  modport sink(input valid, status, ecn_out, ce_marked, instant_mark, persist_mark,
               sojourn_time, out_bytes, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sem_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/sojourn_ecn_marking_queue_core.sv =====
// Sojourn-time ECN marking queue core.
// Requests arrive on the req channel (valid/ready); each transfer is an enqueue
// or a dequeue of the head descriptor. Every request produces exactly one
// transfer on the rsp channel: accepted, dropped, delivered or queue empty.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the core is idle, which the core does not
// enforce. Indexes past the last register are ignored. An enqueue passes S_ENQ
// and S_RESP, a dequeue of an empty queue S_DEQ and S_RESP, a dequeue without
// control-law update S_DEQ, S_EVAL and S_RESP. A dequeue that advances the
// persistent marker evaluates floor(interval / sqrt(count)) with one sequenced
// datapath: 48 shift-add steps to square the interval, 96 restoring division
// steps by the count and 48 square-root digit steps.
// The core handles one request at a time; req.ready is high only when idle.
// The response sits in an output register, so the next request is taken while
// an earlier response still waits; a stalled receiver holds the result only
// when a second response is ready to be written.
// A synchronous reset empties the queue, clears the marker state and loads the
// default limits and times. Descriptor memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sojourn_ecn_marking_queue_core_macros.svh"
module sojourn_ecn_marking_queue_core #(
  parameter int QUEUE_DEPTH = sem_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  sem_req_if.sink                             req,
  sem_rsp_if.source                           rsp,
  input  wire logic                           cfg_we,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sem_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BT_W  = BYTES_W + CNT_W;
  localparam int PK_W  = ((CNT_W > MAXPKT_W) ? CNT_W : MAXPKT_W) + 1;
  localparam int BC_W  = ((BT_W > MAXBYTE_W) ? BT_W : MAXBYTE_W) + 1;
  localparam int ENT_W = TIME_W + BYTES_W + ECN_W;
  localparam int ACC_W = 2 * TIME_W;
  localparam int REM_W = TIME_W + 1;

  // Configuration registers.
  logic                 limit_mode;
  logic [MAXPKT_W-1:0]  max_packets;
  logic [MAXBYTE_W-1:0] max_bytes;
  logic [TIME_W-1:0]    instant_threshold;
  logic [TIME_W-1:0]    persist_interval;
  logic [TIME_W-1:0]    persist_target;

  // Queue and marker state.
  state_t               state, state_next;
  logic [PTR_W-1:0]     head_ptr, tail_ptr;
  logic [CNT_W-1:0]     pkt_count;
  logic [BT_W-1:0]      byte_total;
  logic [TIME_W-1:0]    first_above;
  logic                 marking_on;
  logic [TIME_W-1:0]    mark_next;
  logic [COUNT_W-1:0]   mark_count;

  // Latched request and working registers.
  logic                 cur_type;
  logic [TIME_W-1:0]    cur_now;
  logic [BYTES_W-1:0]   cur_bytes;
  logic [ECN_W-1:0]     cur_ecn;
  status_t              res_status;
  logic [TIME_W-1:0]    res_soj;
  logic [BYTES_W-1:0]   res_size;
  logic [ECN_W-1:0]     res_code;
  logic                 res_inst, res_pers;
  logic [ACC_W-1:0]     acc;
  logic [TIME_W-1:0]    sq_src;
  logic [REM_W-1:0]     rem;
  logic [TIME_W-1:0]    root;
  logic [STEP_W-1:0]    step;

  // Output register.
  logic                 rsp_valid;
  logic [STATUS_W-1:0]  rsp_status;
  logic [ECN_W-1:0]     rsp_ecn;
  logic                 rsp_ce, rsp_inst, rsp_pers;
  logic [TIME_W-1:0]    rsp_soj;
  logic [BYTES_W-1:0]   rsp_bytes;

  // Descriptor memory: stamp, size and ECN code of each queued packet.
  logic                 ram_we;
  logic [ENT_W-1:0]     ram_rdata;

  sem_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_ptr),
    .wdata({cur_now, cur_bytes, cur_ecn}),
    .raddr(head_ptr),
    .rdata(ram_rdata)
  );

  logic [TIME_W-1:0]  rd_stamp;
  logic [BYTES_W-1:0] rd_size;
  logic [ECN_W-1:0]   rd_ecn;
  assign rd_stamp = ram_rdata[ENT_W-1 -: TIME_W];
  assign rd_size  = ram_rdata[ECN_W +: BYTES_W];
  assign rd_ecn   = ram_rdata[ECN_W-1:0];

  // Admission check for the latched enqueue.
  logic queue_full, pkt_over, byte_over, enq_drop;
  assign queue_full = pkt_count >= CNT_W'(QUEUE_DEPTH);
  assign pkt_over   = (PK_W'(pkt_count) + PK_W'(1)) > PK_W'(max_packets);
  assign byte_over  = (BC_W'(byte_total) + BC_W'(cur_bytes)) > BC_W'(max_bytes);
  assign enq_drop   = queue_full || (limit_mode && pkt_over) || (!limit_mode && byte_over);

  // Persistent marker decision for the dequeued packet.
  logic              below_target, ok_to_mark, law_go;
  logic [TIME_W-1:0] now_plus_iv;
  assign below_target = res_soj < persist_target;
  assign ok_to_mark   = !below_target && (first_above != '0) && (cur_now > first_above);
  assign now_plus_iv  = sat_add48(cur_now, persist_interval);
  assign law_go       = marking_on && ok_to_mark && (cur_now >= mark_next);

  logic [PTR_W-1:0] head_inc, tail_inc;
  assign head_inc = (32'(head_ptr) + 32'd1 >= 32'(QUEUE_DEPTH)) ? '0 : head_ptr + PTR_W'(1);
  assign tail_inc = (32'(tail_ptr) + 32'd1 >= 32'(QUEUE_DEPTH)) ? '0 : tail_ptr + PTR_W'(1);

  // Shared sequenced arithmetic: squaring, restoring division, square root.
  logic [ACC_W-1:0]   sqr_sum;
  logic [32:0]        div_shift;
  logic               div_ge;
  logic [REM_W+1:0]   sqrt_shift, sqrt_trial;
  logic               sqrt_ge;
  logic               rsp_free;

  assign sqr_sum    = {acc[ACC_W-2:0], 1'b0} +
                      (sq_src[TIME_W-1] ? ACC_W'(persist_interval) : '0);
  assign div_shift  = {rem[31:0], acc[ACC_W-1]};
  assign div_ge     = div_shift >= {1'b0, mark_count};
  assign sqrt_shift = {rem, acc[ACC_W-1 -: 2]};
  assign sqrt_trial = {1'b0, root, 2'b01};
  assign sqrt_ge    = sqrt_shift >= sqrt_trial;
  assign rsp_free   = !rsp_valid || rsp.ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) begin
        state_next = req.req_type ? S_DEQ : S_ENQ;
      end
      S_ENQ:  state_next = S_RESP;
      S_DEQ:  state_next = (pkt_count == '0) ? S_RESP : S_EVAL;
      S_EVAL: state_next = law_go ? S_SQR : S_RESP;
      S_SQR:  if (step == STEP_W'(SQR_STEPS - 1)) begin
        state_next = S_DIV;
      end
      S_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) begin
        state_next = S_SQRT;
      end
      S_SQRT: if (step == STEP_W'(SQRT_STEPS - 1)) begin
        state_next = S_LAW;
      end
      S_LAW:  state_next = S_RESP;
      S_RESP: if (rsp_free) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    unique case (state)
      S_IDLE:  req.ready = 1'b1;
      S_ENQ:   ram_we = !enq_drop;
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_mode        <= 1'b0;
      max_packets       <= MAX_PACKETS_RST;
      max_bytes         <= MAX_BYTES_RST;
      instant_threshold <= INSTANT_RST;
      persist_interval  <= INTERVAL_RST;
      persist_target    <= TARGET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIMIT_MODE:  limit_mode        <= cfg_data[0];
        CFG_MAX_PACKETS: max_packets       <= cfg_data[MAXPKT_W-1:0];
        CFG_MAX_BYTES:   max_bytes         <= cfg_data[MAXBYTE_W-1:0];
        CFG_INSTANT:     instant_threshold <= cfg_data[TIME_W-1:0];
        CFG_INTERVAL:    persist_interval  <= cfg_data[TIME_W-1:0];
        CFG_TARGET:      persist_target    <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Queue and marker control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      pkt_count   <= '0;
      byte_total  <= '0;
      first_above <= '0;
      marking_on  <= 1'b0;
      mark_next   <= '0;
      mark_count  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ENQ && !enq_drop) begin
        tail_ptr   <= tail_inc;
        pkt_count  <= pkt_count + CNT_W'(1);
        byte_total <= byte_total + BT_W'(cur_bytes);
      end
      if (state == S_EVAL) begin
        head_ptr   <= head_inc;
        pkt_count  <= pkt_count - CNT_W'(1);
        byte_total <= (byte_total >= BT_W'(res_size)) ? byte_total - BT_W'(res_size) : '0;
        if (below_target) begin
          first_above <= '0;
        end else if (first_above == '0) begin
          first_above <= now_plus_iv;
        end
        if (marking_on) begin
          if (!ok_to_mark) begin
            marking_on <= 1'b0;
          end else if (law_go && mark_count != {COUNT_W{1'b1}}) begin
            mark_count <= mark_count + COUNT_W'(1);
          end
        end else if (ok_to_mark) begin
          marking_on <= 1'b1;
          mark_count <= COUNT_W'(1);
          mark_next  <= now_plus_iv;
        end
      end
      if (state == S_LAW) begin
        mark_next <= sat_add48(cur_now, root);
      end
      if (state == S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur_type  <= req.req_type;
      cur_now   <= req.now_time;
      cur_bytes <= req.pkt_bytes;
      cur_ecn   <= req.ecn_in;
    end
    case (state)
      S_ENQ: res_status <= enq_drop ? STAT_DROPPED : STAT_ACCEPTED;
      S_DEQ: begin
        res_status <= (pkt_count == '0) ? STAT_EMPTY : STAT_DELIVERED;
        res_soj    <= (cur_now >= rd_stamp) ? cur_now - rd_stamp : '0;
        res_size   <= rd_size;
        res_code   <= rd_ecn;
        res_inst   <= 1'b0;
        res_pers   <= 1'b0;
      end
      S_EVAL: begin
        res_inst <= res_soj > instant_threshold;
        res_pers <= law_go || (!marking_on && ok_to_mark);
        acc      <= '0;
        sq_src   <= persist_interval;
        step     <= '0;
      end
      S_SQR: begin
        acc    <= sqr_sum;
        sq_src <= {sq_src[TIME_W-2:0], 1'b0};
        rem    <= '0;
        step   <= (step == STEP_W'(SQR_STEPS - 1)) ? '0 : step + STEP_W'(1);
      end
      S_DIV: begin
        // The square root starts from a cleared remainder once the quotient is complete.
        rem  <= (step == STEP_W'(DIV_STEPS - 1)) ? '0 :
                REM_W'(div_ge ? div_shift - {1'b0, mark_count} : div_shift);
        acc  <= {acc[ACC_W-2:0], div_ge};
        step <= (step == STEP_W'(DIV_STEPS - 1)) ? '0 : step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          root <= '0;
        end
      end
      S_SQRT: begin
        rem  <= sqrt_ge ? REM_W'(sqrt_shift - sqrt_trial) : REM_W'(sqrt_shift);
        root <= {root[TIME_W-2:0], sqrt_ge};
        acc  <= {acc[ACC_W-3:0], 2'b00};
        step <= step + STEP_W'(1);
      end
      S_RESP: if (rsp_free) begin
        rsp_status <= res_status;
        if (res_status == STAT_DELIVERED) begin
          rsp_ce    <= (res_inst || res_pers) && (res_code == ECN_MARKABLE);
          rsp_ecn   <= ((res_inst || res_pers) && (res_code == ECN_MARKABLE)) ? ECN_CE : res_code;
          rsp_inst  <= res_inst;
          rsp_pers  <= res_pers;
          rsp_soj   <= res_soj;
          rsp_bytes <= res_size;
        end else begin
          rsp_ce    <= 1'b0;
          rsp_ecn   <= '0;
          rsp_inst  <= 1'b0;
          rsp_pers  <= 1'b0;
          rsp_soj   <= '0;
          rsp_bytes <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.ecn_out      = rsp_ecn;
  assign rsp.ce_marked    = rsp_ce;
  assign rsp.instant_mark = rsp_inst;
  assign rsp.persist_mark = rsp_pers;
  assign rsp.sojourn_time = rsp_soj;
  assign rsp.out_bytes    = rsp_bytes;

  // The occupancy never passes the memory depth.
  `SEM_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, pkt_count <= CNT_W'(QUEUE_DEPTH))
  // A request transfer always starts work: the core is busy in the next cycle.
  `SEM_ASSERT_NEXT(a_busy_after_req, clk, rst, req.valid && req.ready, state != S_IDLE)
  // Marking mode always carries a nonzero mark count.
  `SEM_ASSERT_IMP(a_mark_count, clk, rst, marking_on, mark_count != '0)
  // The latched request kind matches the enqueue branch the sequencer took.
  `SEM_ASSERT_IMP(a_kind_enq, clk, rst, state == S_ENQ, !cur_type)

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sem_pkg::*;

  localparam int  DEPTH       = 1024;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

  // One request as the sender presents it.
  typedef struct packed {
    logic               req_type;
    logic [TIME_W-1:0]  now_time;
    logic [BYTES_W-1:0] pkt_bytes;
    logic [ECN_W-1:0]   ecn_in;
  } request_t;

  // One response as the receiver sees it.
  typedef struct packed {
    status_t            status;
    logic [ECN_W-1:0]   ecn_out;
    logic               ce_marked;
    logic               instant_mark;
    logic               persist_mark;
    logic [TIME_W-1:0]  sojourn_time;
    logic [BYTES_W-1:0] out_bytes;
  } response_t;

  // A queued packet descriptor in the predictor.
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [BYTES_W-1:0] size;
    logic [ECN_W-1:0]   ecn;
  } descriptor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int   errors = 0;
  int   cycles = 0;

  sem_req_if req ();
  sem_rsp_if rsp ();

  sojourn_ecn_marking_queue_core dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // The queue predictor and the store of expected responses live together: every
  // accepted request advances the predicted queue and leaves one expectation.
  class marking_queue_scoreboard;
    logic                 limit_mode;
    logic [MAXPKT_W-1:0]  max_packets;
    logic [MAXBYTE_W-1:0] max_bytes;
    logic [TIME_W-1:0]    instant_threshold, persist_interval, persist_target;
    descriptor_t          held[$];
    logic [63:0]          byte_total;
    logic [TIME_W-1:0]    first_above, mark_next;
    logic                 marking_on;
    logic [COUNT_W-1:0]   mark_count;
    response_t            pending[$];

    function new();
      limit_mode = 1'b0;
      max_packets = MAX_PACKETS_RST;
      max_bytes = MAX_BYTES_RST;
      instant_threshold = INSTANT_RST;
      persist_interval = INTERVAL_RST;
      persist_target = TARGET_RST;
      byte_total = '0;
      first_above = '0;
      mark_next = '0;
      marking_on = 1'b0;
      mark_count = '0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LIMIT_MODE:  limit_mode = value[0];
        CFG_MAX_PACKETS: max_packets = value[MAXPKT_W-1:0];
        CFG_MAX_BYTES:   max_bytes = value[MAXBYTE_W-1:0];
        CFG_INSTANT:     instant_threshold = value[TIME_W-1:0];
        CFG_INTERVAL:    persist_interval = value[TIME_W-1:0];
        CFG_TARGET:      persist_target = value[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TMAX : s[TIME_W-1:0];
    endfunction

    // Largest q with q*q*count <= interval*interval, a zero count taken as one.
    function logic [TIME_W-1:0] mark_spacing(logic [TIME_W-1:0] iv, logic [COUNT_W-1:0] c);
      logic [127:0] square, trial;
      logic [TIME_W-1:0] q, t;
      if (c == 0) c = 1;
      square = {80'b0, iv} * {80'b0, iv};
      q = '0;
      for (int b = TIME_W - 1; b >= 0; b--) begin
        t = q | (TIME_W'(1) << b);
        trial = {80'b0, t} * {80'b0, t} * {96'b0, c};
        if (trial <= square) q = t;
      end
      return q;
    endfunction

    function void note_request(request_t r);
      response_t   e;
      descriptor_t d;
      logic [TIME_W-1:0] soj;
      logic drop, inst, pers, ok;
      e = '0;
      if (r.req_type == 1'b0) begin
        drop = held.size() >= DEPTH;
        if (limit_mode && held.size() + 1 > max_packets) drop = 1'b1;
        if (!limit_mode && byte_total + r.pkt_bytes > max_bytes) drop = 1'b1;
        if (drop) e.status = STAT_DROPPED;
        else begin
          held.push_back('{r.now_time, r.pkt_bytes, r.ecn_in});
          byte_total += r.pkt_bytes;
          e.status = STAT_ACCEPTED;
        end
      end else if (held.size() == 0) begin
        e.status = STAT_EMPTY;
      end else begin
        d = held.pop_front();
        soj = (r.now_time >= d.stamp) ? r.now_time - d.stamp : '0;
        inst = soj > instant_threshold;
        pers = 1'b0;
        ok = 1'b0;
        byte_total = (byte_total >= d.size) ? byte_total - d.size : '0;
        if (soj < persist_target) first_above = '0;
        else if (first_above == 0) first_above = add_sat(r.now_time, persist_interval);
        else if (r.now_time > first_above) ok = 1'b1;
        if (marking_on) begin
          if (!ok) marking_on = 1'b0;
          else if (r.now_time >= mark_next) begin
            if (mark_count != '1) mark_count++;
            mark_next = add_sat(r.now_time, mark_spacing(persist_interval, mark_count));
            pers = 1'b1;
          end
        end else if (ok) begin
          marking_on = 1'b1;
          mark_count = 1;
          mark_next = add_sat(r.now_time, persist_interval);
          pers = 1'b1;
        end
        e.status = STAT_DELIVERED;
        e.ecn_out = d.ecn;
        if ((inst || pers) && d.ecn == ECN_MARKABLE) begin
          e.ecn_out = ECN_CE;
          e.ce_marked = 1'b1;
        end
        e.instant_mark = inst;
        e.persist_mark = pers;
        e.sojourn_time = soj;
        e.out_bytes = d.size;
      end
      pending.push_back(e);
    endfunction

    function void check_response(response_t a);
      response_t e;
      if (pending.size() == 0) begin
        $display("%0t: response with none expected: %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        $display("%0t: response mismatch: expected %p, actual %p", $time, e, a);
        errors++;
      end
    endfunction
  endclass

  marking_queue_scoreboard sb = new();

  // The receiver alternates between long stretches of steady acceptance and
  // stretches in which it stalls at random.
  initial begin
    rsp.ready = 1'b0;
    req.valid = 1'b0;
    req.req_type = 1'b0;
    req.now_time = '0;
    req.pkt_bytes = '0;
    req.ecn_in = '0;
  end

  always @(negedge clk) begin
    if ((cycles / 700) % 3 == 0) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 2) != 0);
  end

  // Responses are taken at the rising edge on which valid and ready are both high.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready)
      sb.check_response('{status_t'(rsp.status), rsp.ecn_out, rsp.ce_marked,
                          rsp.instant_mark, rsp.persist_mark, rsp.sojourn_time,
                          rsp.out_bytes});
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  int burst_left = 0;

  // Presents one request and holds it until the transfer. Valid is left high at
  // the end of each request so the next request of a burst follows back to back;
  // between bursts it drops for a random gap, unless that gap is drawn as zero.
  task automatic send_request(request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.valid = 1'b1;
    req.req_type = r.req_type;
    req.now_time = r.now_time;
    req.pkt_bytes = r.pkt_bytes;
    req.ecn_in = r.ecn_in;
    do @(posedge clk); while (!(req.valid && req.ready));
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Register writes happen only once every expected response has come back.
  task automatic settle();
    req.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic enqueue(logic [TIME_W-1:0] t, logic [BYTES_W-1:0] b, logic [ECN_W-1:0] e);
    send_request('{1'b0, t, b, e});
  endtask

  task automatic dequeue(logic [TIME_W-1:0] t);
    send_request('{1'b1, t, BYTES_W'($urandom), ECN_W'($urandom)});
  endtask

  logic [TIME_W-1:0] clock_ns;

  // A random phase: queue occupancy wanders with the enqueue share, and time
  // advances in steps of the given scale so sojourns straddle the thresholds.
  task automatic random_phase(int n, int enq_pct, int step);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) == 0)
        clock_ns = clock_ns - TIME_W'($urandom_range(0, step));
      else
        clock_ns = sb.add_sat(clock_ns, TIME_W'($urandom_range(0, step)));
      if ($urandom_range(0, 99) < enq_pct)
        enqueue(clock_ns, BYTES_W'($urandom_range(1, 65535)), ECN_W'($urandom));
      else
        dequeue(clock_ns);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] iv;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every ECN code, an empty dequeue, instant
    // marking and time running backwards, all under the reset settings.
    dequeue(TIME_W'(5));
    enqueue('0, 16'd1, 2'd0);
    enqueue(TIME_W'(10), 16'hFFFF, 2'd1);
    enqueue(TIME_W'(20), 16'h5555, 2'd2);
    enqueue(TIME_W'(30), 16'hAAAA, 2'd3);
    enqueue(TIME_W'(40), 16'd1500, 2'd1);
    dequeue(TIME_W'(100));
    dequeue(TIME_W'(50000));
    dequeue(TIME_W'(60000));
    dequeue(TIME_W'(70000));
    dequeue(TIME_W'(20));
    dequeue(TIME_W'(80000));
    enqueue(TMAX, 16'd7, 2'd1);
    dequeue('0);

    // Zero interval and target: the first-above sum is zero at time zero, and
    // zero limits drop every enqueue in either mode.
    settle();
    write_register(CFG_INTERVAL, '0);
    write_register(CFG_TARGET, '0);
    write_register(CFG_INSTANT, '1);
    enqueue('0, 16'd64, 2'd1);
    enqueue('0, 16'd64, 2'd1);
    enqueue('0, 16'd64, 2'd1);
    dequeue('0);
    dequeue(TIME_W'(1));
    dequeue(TIME_W'(2));
    settle();
    write_register(CFG_MAX_BYTES, '0);
    enqueue(TIME_W'(3), 16'd1, 2'd2);
    settle();
    write_register(CFG_LIMIT_MODE, 1);
    write_register(CFG_MAX_PACKETS, '0);
    enqueue(TIME_W'(3), 16'd1, 2'd2);

    // Fill to the full depth with the widest limits, then drain.
    settle();
    write_register(CFG_MAX_PACKETS, 48'hFFFF_FFFF_FFFF);
    write_register(CFG_LIMIT_MODE, 0);
    write_register(CFG_MAX_BYTES, 48'hFFFF_FFFF_FFFF);
    write_register(CFG_INTERVAL, '1);
    write_register(CFG_TARGET, '1);
    for (int i = 0; i < DEPTH + 3; i++) enqueue(TIME_W'(1000), 16'd1, ECN_W'(i));
    for (int i = 0; i < DEPTH + 1; i++) dequeue(TIME_W'(1000));

    // Random phases over a spread of settings, extremes included.
    clock_ns = '0;
    for (int p = 0; p < 8; p++) begin
      settle();
      write_register(CFG_LIMIT_MODE, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: write_register(CFG_MAX_PACKETS, 1);
        1: write_register(CFG_MAX_PACKETS, 1024);
        default: write_register(CFG_MAX_PACKETS, $urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 3))
        0: write_register(CFG_MAX_BYTES, 24'hFFFFFF);
        1: write_register(CFG_MAX_BYTES, 1);
        default: write_register(CFG_MAX_BYTES, $urandom_range(65535, 1000000));
      endcase
      if (p == 6) begin
        // Near the top of the time range the sums saturate.
        clock_ns = TMAX - TIME_W'(200000);
        iv = TIME_W'({$urandom, $urandom});
        write_register(CFG_INTERVAL, (p % 2) ? iv : TMAX);
        write_register(CFG_TARGET, $urandom_range(0, 500));
        write_register(CFG_INSTANT, TMAX - 1);
        random_phase(200, 50, 2000);
      end else begin
        iv = (p == 2) ? TIME_W'(1) : TIME_W'($urandom_range(20, 4000));
        write_register(CFG_INTERVAL, iv);
        write_register(CFG_TARGET, (p == 3) ? '0 : TIME_W'($urandom_range(0, 600)));
        write_register(CFG_INSTANT, (p == 4) ? '0 : TIME_W'($urandom_range(0, 3000)));
        random_phase(230, $urandom_range(35, 65), $urandom_range(10, 300));
      end
    end

    settle();
    repeat (250) @(negedge clk);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
